### rtl/jsu_pkg.sv
// jsu_pkg: shared types and codes of the json string unescape unit
// depends on nothing; used by all rtl and checker files
`default_nettype none

package jsu_pkg;

    localparam int unsigned MaxResults = 3;

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } load_t;

endpackage

`default_nettype wire

### rtl/jsu_outq.sv
// jsu_outq: result queue of up to three words, shifted toward the output slot
// depends on jsu_pkg
`default_nettype none

module jsu_outq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire jsu_pkg::load_t      load,
    input  wire jsu_pkg::result_t    res_in [jsu_pkg::MaxResults],
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output jsu_pkg::result_t         head
);
    import jsu_pkg::*;

    result_t    slot_reg [MaxResults];
    logic [1:0] count_reg;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign head    = slot_reg[0];
    // empty now or empty after this cycle's pop
    assign room    = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (load.load) begin
            count_reg <= load.count;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.load) begin
            slot_reg <= res_in;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

### rtl/json_string_unescape_utf8_unit.sv
// json_string_unescape_utf8_unit: top level, string decoder state and utf-8 encoding
// depends on jsu_pkg and jsu_outq
//
// usage
// input channel s_valid/s_ready/s_in_byte carries one byte of json text per word,
// starting at the opening quote of a string literal. result channel
// m_valid/m_ready carries m_out_byte, m_status (byte, complete, error) and
// m_last_of_run, which marks the final result word caused by one input byte.
// an input byte is decoded in the cycle it is taken and its results appear
// in the next cycle, from a queue of up to three words. a plain byte or a
// short escape flows at one word per cycle while the receiver is ready. the
// fourth hex digit of a \u escape may yield three words; the queue then
// drains one word per cycle and input waits until the last of them is being
// taken. input is taken whenever the queue is empty or its only word leaves
// in the same cycle; a stalled receiver holds the head word and stops input.
// reset empties the queue and returns the decoder to idle, waiting for an
// opening quote.
`default_nettype none

module json_string_unescape_utf8_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_status,
    output logic            m_last_of_run
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  digits_reg, digits_next;
    logic [11:0] accum_reg, accum_next;

    result_t     res [MaxResults];
    result_t     head;
    load_t       load;
    logic [1:0]  n_res;
    logic        room;
    logic        hex_ok;
    logic [3:0]  nib;
    logic [15:0] cp;
    logic [7:0]  esc_byte;
    logic        esc_ok;

    always_comb begin
        hex_ok = 1'b1;
        nib    = s_in_byte[3:0];
        if (s_in_byte inside {[8'h30:8'h39]}) begin
            nib = s_in_byte[3:0];
        end else if (s_in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            nib = s_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp = {accum_reg, nib};

    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = s_in_byte;
        case (s_in_byte)
            CH_QUOTE:  esc_byte = CH_QUOTE;
            CH_BSLASH: esc_byte = CH_BSLASH;
            CH_SLASH:  esc_byte = CH_SLASH;
            CH_LOW_B:  esc_byte = CH_BS;
            CH_LOW_F:  esc_byte = CH_FF;
            CH_LOW_N:  esc_byte = CH_LF;
            CH_LOW_R:  esc_byte = CH_CR;
            CH_LOW_T:  esc_byte = CH_TAB;
            default:   esc_ok   = 1'b0;
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        accum_next  = accum_reg;
        n_res       = 2'd0;
        for (int i = 0; i < MaxResults; i++) begin
            res[i] = '0;
        end
        case (mode_reg)
            MODE_IDLE: begin
                if (s_in_byte == CH_QUOTE) begin
                    mode_next = MODE_STR;
                end else begin
                    res[0] = '{8'h00, ST_ERR, 1'b1};
                    n_res  = 2'd1;
                end
            end
            MODE_STR: begin
                if (s_in_byte == CH_QUOTE) begin
                    mode_next = MODE_IDLE;
                    res[0]    = '{8'h00, ST_DONE, 1'b1};
                    n_res     = 2'd1;
                end else if (s_in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else if (s_in_byte < CTRL_LIMIT) begin
                    mode_next = MODE_IDLE;
                    res[0]    = '{8'h00, ST_ERR, 1'b1};
                    n_res     = 2'd1;
                end else begin
                    res[0] = '{s_in_byte, ST_BYTE, 1'b1};
                    n_res  = 2'd1;
                end
            end
            MODE_ESC: begin
                if (s_in_byte == CH_LOW_U) begin
                    mode_next   = MODE_HEX;
                    digits_next = 2'd0;
                    accum_next  = 12'd0;
                end else if (esc_ok) begin
                    mode_next = MODE_STR;
                    res[0]    = '{esc_byte, ST_BYTE, 1'b1};
                    n_res     = 2'd1;
                end else begin
                    mode_next = MODE_IDLE;
                    res[0]    = '{8'h00, ST_ERR, 1'b1};
                    n_res     = 2'd1;
                end
            end
            default: begin
                digits_next = 2'd0;
                accum_next  = 12'd0;
                if (!hex_ok || ((digits_reg == 2'd3) && (cp[15:11] == 5'b11011))) begin
                    // bad digit or surrogate code
                    mode_next = MODE_IDLE;
                    res[0]    = '{8'h00, ST_ERR, 1'b1};
                    n_res     = 2'd1;
                end else if (digits_reg != 2'd3) begin
                    digits_next = digits_reg + 2'd1;
                    accum_next  = {accum_reg[7:0], nib};
                end else begin
                    mode_next = MODE_STR;
                    if (cp[15:7] == 9'd0) begin
                        res[0] = '{cp[7:0], ST_BYTE, 1'b1};
                        n_res  = 2'd1;
                    end else if (cp[15:11] == 5'd0) begin
                        res[0] = '{{3'b110, cp[10:6]}, ST_BYTE, 1'b0};
                        res[1] = '{{2'b10, cp[5:0]}, ST_BYTE, 1'b1};
                        n_res  = 2'd2;
                    end else begin
                        res[0] = '{{4'b1110, cp[15:12]}, ST_BYTE, 1'b0};
                        res[1] = '{{2'b10, cp[11:6]}, ST_BYTE, 1'b0};
                        res[2] = '{{2'b10, cp[5:0]}, ST_BYTE, 1'b1};
                        n_res  = 2'd3;
                    end
                end
            end
        endcase
    end

    assign s_ready = room;
    assign load    = '{s_valid && room, n_res};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            digits_reg <= 2'd0;
            accum_reg  <= 12'd0;
        end else if (load.load) begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            accum_reg  <= accum_next;
        end
    end

    jsu_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .res_in  (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_out_byte    = head.out_byte;
    assign m_status      = head.status;
    assign m_last_of_run = head.last_of_run;

endmodule

`default_nettype wire

### rtl/jsu_checker.sv
// jsu_checker: port-level checks of the json string unescape unit, bound to the top level
// depends on jsu_pkg and json_string_unescape_utf8_unit
`default_nettype none

module jsu_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic [1:0] m_status,
    input wire logic       m_last_of_run
);
    import jsu_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_status)
            && $stable(m_last_of_run))
        else $error("stalled result word changed");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_BYTE) || (m_status == ST_DONE) || (m_status == ST_ERR))
        else $error("unused status code");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_BYTE) |-> m_last_of_run && (m_out_byte == 8'h00))
        else $error("completion or error word malformed");

    // more words of a run still queued, no new input
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("input taken while a run is pending");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_byte    (m_out_byte),
    .m_status      (m_status),
    .m_last_of_run (m_last_of_run)
);

`default_nettype wire
